/* rtl/bba_pkg.sv */
// bba_pkg: shared types and constants of the bitmap block allocator
// beat structs, request kinds, status codes, register map of the apb port
// no dependencies
`default_nettype none

package bba_pkg;

  localparam int unsigned CFG_W  = 17;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [CFG_W-1:0] TOTAL_RESET    = 17'd65536;
  localparam logic [CFG_W-1:0] RESERVED_RESET = 17'd0;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_TEST   = 2'd2,
    KIND_FORMAT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    REG_TOTAL    = 1'b0,
    REG_RESERVED = 1'b1
  } reg_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  block_index;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  result_block;
    logic              bit_value;
    logic [CFG_W-1:0]  free_left;
    status_e           status;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_W-1:0]  total_blocks;
    logic [CFG_W-1:0]  reserved_blocks;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/bba_map_ram.sv */
// bba_map_ram: occupancy map storage, one write port and one read port
// read data registered, available in the cycle after the read; no dependencies
`default_nettype none

module bba_map_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/bba_cfg_regs.sv */
// bba_cfg_regs: apb register file holding total and reserved block counts
// depends on bba_pkg
`default_nettype none

module bba_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bba_pkg::ADDR_W-1:0] paddr,
  input  logic [bba_pkg::DATA_W-1:0] pwdata,
  output logic [bba_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bba_pkg::cfg_t              cfg_o
);
  import bba_pkg::*;

  logic [CFG_W-1:0] total_q;
  logic [CFG_W-1:0] reserved_q;
  logic             wr_en;
  reg_e             sel;

  assign wr_en  = psel & penable & pwrite;
  assign sel    = reg_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= TOTAL_RESET;
      reserved_q <= RESERVED_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_TOTAL:    total_q    <= pwdata[CFG_W-1:0];
        REG_RESERVED: reserved_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_TOTAL:    prdata = {{(DATA_W-CFG_W){1'b0}}, total_q};
      REG_RESERVED: prdata = {{(DATA_W-CFG_W){1'b0}}, reserved_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.total_blocks    = total_q;
  assign cfg_o.reserved_blocks = reserved_q;

endmodule

`default_nettype wire

/* rtl/bba_ctrl.sv */
// bba_ctrl: request sequencer, read-modify-write of map words, first-fit scan
// keeps free count, scan hint and output register; depends on bba_pkg
`default_nettype none

module bba_ctrl #(
  parameter int unsigned MAX_BLOCKS = 65536,
  parameter int unsigned WORD_BITS  = 64,
  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bba_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bba_pkg::in_beat_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bba_pkg::out_beat_t   out_data_o,
  output logic                 mem_we_o,
  output logic                 mem_re_o,
  output logic [AW-1:0]        mem_addr_o,
  output logic [WORD_BITS-1:0] mem_wdata_o,
  input  logic [WORD_BITS-1:0] mem_rdata_i
);
  import bba_pkg::*;

  localparam int unsigned HW  = $clog2(MAP_WORDS + 1);
  localparam int unsigned PW  = $clog2(MAX_BLOCKS);
  localparam int unsigned CW  = ($clog2(MAX_BLOCKS + 1) > CFG_W) ?
                                $clog2(MAX_BLOCKS + 1) : CFG_W;
  localparam int unsigned VW  = CW + 1;
  localparam int unsigned BW  = $clog2(WORD_BITS);
  localparam int unsigned SH  = PW + BW;
  localparam int unsigned MW  = PW + 2;
  localparam int unsigned RW  = PW + MW;
  localparam logic [MW-1:0] RECIP = MW'((2**SH + WORD_BITS - 1) / WORD_BITS);

  typedef enum logic [2:0] {
    ST_FMT,
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic             init_q, init_d;
  logic [HW-1:0]    scan_q, scan_d;
  logic [HW-1:0]    hint_q, hint_d;
  logic [AW-1:0]    word_q, word_d;
  logic [BW-1:0]    bit_q, bit_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  kind_e            kind_q, kind_d;
  logic [VW-1:0]    rsv_q, rsv_d;
  logic [CW-1:0]    free_q, free_d;
  logic [IDX_W-1:0] res_block_q, res_block_d;
  logic             res_bit_q, res_bit_d;
  status_e          res_status_q, res_status_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  logic [VW-1:0]        eff_total;
  logic [VW-1:0]        rsv_clip;
  logic [VW-1:0]        idx_ext;
  logic [RW-1:0]        prod;
  logic [VW-1:0]        scan_base;
  logic [VW-1:0]        rem_full;
  logic [WORD_BITS-1:0] fmt_word;
  logic [WORD_BITS-1:0] inv_word;
  logic [WORD_BITS-1:0] low_zero;
  logic [BW-1:0]        ffz;
  logic [VW-1:0]        alloc_pos;
  logic [VW-1:0]        free_inc;
  logic [CW-1:0]        free_dec;

  assign eff_total = (VW'(cfg_i.total_blocks) > VW'(MAX_BLOCKS)) ?
                     VW'(MAX_BLOCKS) : VW'(cfg_i.total_blocks);
  assign rsv_clip  = (VW'(cfg_i.reserved_blocks) > eff_total) ?
                     eff_total : VW'(cfg_i.reserved_blocks);
  assign idx_ext   = VW'(in_data_i.block_index);
  // word index by reciprocal multiply, exact for all in-range positions
  assign prod      = RW'(idx_ext[PW-1:0]) * RW'(RECIP);
  assign scan_base = VW'(scan_q) * VW'(WORD_BITS);
  assign rem_full  = VW'(idx_q) - VW'(word_q) * VW'(WORD_BITS);
  assign inv_word  = ~mem_rdata_i;
  assign low_zero  = inv_word & (~inv_word + WORD_BITS'(1));
  assign alloc_pos = scan_base + VW'(ffz);
  assign free_inc  = VW'(free_q) + VW'(1);
  assign free_dec  = free_q - CW'(1);

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      fmt_word[j] = (scan_base + VW'(j)) < rsv_q;
    end
  end

  // encode the isolated lowest zero bit
  always_comb begin
    ffz = '0;
    for (int b = 0; b < BW; b++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (((j >> b) & 1) == 1) begin
          ffz[b] = ffz[b] | low_zero[j];
        end
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    scan_d       = scan_q;
    hint_d       = hint_q;
    word_d       = word_q;
    bit_d        = bit_q;
    idx_d        = idx_q;
    kind_d       = kind_q;
    rsv_d        = rsv_q;
    free_d       = free_q;
    res_block_d  = res_block_q;
    res_bit_d    = res_bit_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    mem_addr_o   = scan_q[AW-1:0];
    mem_wdata_o  = fmt_word;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_FMT: begin
        mem_we_o = 1'b1;
        if (scan_q == HW'(MAP_WORDS - 1)) begin
          scan_d = '0;
          hint_d = '0;
          if (init_q) begin
            init_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            free_d  = CW'(eff_total - rsv_q);
            state_d = ST_FINISH;
          end
        end else begin
          scan_d = scan_q + HW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d       = in_data_i.kind;
          idx_d        = in_data_i.block_index;
          word_d       = prod[SH +: AW];
          res_block_d  = '0;
          res_bit_d    = 1'b0;
          res_status_d = STATUS_OK;
          case (in_data_i.kind)
            KIND_ALLOC: begin
              if (free_q == '0) begin
                res_status_d = STATUS_FULL;
                state_d      = ST_FINISH;
              end else begin
                scan_d  = hint_q;
                state_d = ST_SCAN_RD;
              end
            end
            KIND_FREE, KIND_TEST: begin
              if (idx_ext >= eff_total) begin
                res_status_d = STATUS_RANGE;
                state_d      = ST_FINISH;
              end else begin
                state_d = ST_READ;
              end
            end
            KIND_FORMAT: begin
              rsv_d   = rsv_clip;
              scan_d  = '0;
              state_d = ST_FMT;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_READ: begin
        mem_re_o   = 1'b1;
        mem_addr_o = word_q;
        bit_d      = rem_full[BW-1:0];
        state_d    = ST_MOD;
      end
      ST_MOD: begin
        mem_addr_o  = word_q;
        res_block_d = idx_q;
        if (kind_q == KIND_TEST) begin
          res_bit_d = mem_rdata_i[bit_q];
        end else begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i & ~(WORD_BITS'(1) << bit_q);
          free_d      = (free_inc > eff_total) ? CW'(eff_total) : CW'(free_inc);
          if (HW'(word_q) < hint_q) begin
            hint_d = HW'(word_q);
          end
        end
        state_d = ST_FINISH;
      end
      ST_SCAN_RD: begin
        if (scan_q >= HW'(MAP_WORDS) || scan_base >= eff_total) begin
          hint_d       = scan_q;
          res_status_d = STATUS_FULL;
          state_d      = ST_FINISH;
        end else begin
          mem_re_o = 1'b1;
          state_d  = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (mem_rdata_i != '1) begin
          hint_d = scan_q;
          if (alloc_pos >= eff_total) begin
            res_status_d = STATUS_FULL;
          end else begin
            mem_we_o    = 1'b1;
            mem_wdata_o = mem_rdata_i | low_zero;
            free_d      = CW'(free_dec[CFG_W-1:0]);
            res_block_d = alloc_pos[IDX_W-1:0];
          end
          state_d = ST_FINISH;
        end else begin
          scan_d  = scan_q + HW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.result_block = res_block_q;
          out_d.bit_value    = res_bit_q;
          out_d.free_left    = free_q[CFG_W-1:0];
          out_d.status       = res_status_q;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FMT;
      init_q       <= 1'b1;
      scan_q       <= '0;
      hint_q       <= '0;
      word_q       <= '0;
      bit_q        <= '0;
      idx_q        <= '0;
      kind_q       <= KIND_ALLOC;
      rsv_q        <= '0;
      free_q       <= CW'(MAX_BLOCKS);
      res_block_q  <= '0;
      res_bit_q    <= 1'b0;
      res_status_q <= STATUS_OK;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      scan_q       <= scan_d;
      hint_q       <= hint_d;
      word_q       <= word_d;
      bit_q        <= bit_d;
      idx_q        <= idx_d;
      kind_q       <= kind_d;
      rsv_q        <= rsv_d;
      free_q       <= free_d;
      res_block_q  <= res_block_d;
      res_bit_q    <= res_bit_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while a request is in flight");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("map read and write in the same cycle");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result beat raised outside the finish step");

  a_hint_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= HW'(MAP_WORDS))
    else $error("scan hint beyond the map");
`endif

endmodule

`default_nettype wire

/* rtl/bitmap_block_allocator_top.sv */
// allocate reads words from the hint to the first zero bit; free rewrites one word;
// test reads one; range errors, allocate at zero free skip the map; format rewrites all
// throughput: one request at a time, set by the read-modify-write on the map memory port
// a scan hint skips words known full, so allocate usually reads one word
// reset: a clearing pass zeroes all MAP_WORDS map words (1024 by default), stall held
// high meanwhile; apb writes are taken throughout
`default_nettype none

module bitmap_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 65536,
  parameter int unsigned WORD_BITS  = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bba_pkg::in_beat_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bba_pkg::out_beat_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bba_pkg::ADDR_W-1:0] paddr,
  input  logic [bba_pkg::DATA_W-1:0] pwdata,
  output logic [bba_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bba_pkg::*;

  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  cfg_t                 cfg;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  bba_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  bba_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
